/* sv/command_chunk_framer_top_defines.svh */
// ---------------------------------------------------------------------------
// Command chunk framer assertion macros
// Shared property forms for the framer's checks.
// ---------------------------------------------------------------------------
`ifndef COMMAND_CHUNK_FRAMER_TOP_DEFINES_SVH
`define COMMAND_CHUNK_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCF_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("framer check failed");

// Next-cycle implication, always active.
`define CCF_ASSERT_NEXT(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("framer check failed");

`endif

/* sv/ccf_pkg.sv */
// ---------------------------------------------------------------------------
// Command chunk framer package
// Types, result codes and the per-id command length rule table.
// ---------------------------------------------------------------------------
`default_nettype none

package ccf_pkg;

   localparam logic [15:0] MAX_COUNT_RESET = 16'd10000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_IGNORE, PH_HEADER, PH_AWAIT, PH_BODY, PH_STRING, PH_FINISH, PH_DRAIN
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE, K_FIXED, K_STD, K_ARR28, K_ARR31, K_B2D, K_B8B
   } kind_type;

   typedef enum logic [2:0] {
      ST_COMMAND, ST_UNKNOWN, ST_INC_FIXED, ST_INC_STD, ST_INC_BESPOKE,
      ST_BAD_HEADER, ST_OVER_LIMIT, ST_DONE
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [10:0] param;
   } rule_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  command_id;
      logic [7:0]  player_index;
      logic [15:0] command_length;
      logic [15:0] command_offset;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              room;
   } q_status_type;

   function automatic rule_type rom_rule(input logic [7:0] id);
      rule_type r;
      r.kind  = K_NONE;
      r.param = 11'd0;
      case (id)
         8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B,
         8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h17, 8'h72, 8'h73, 8'h4C,
         8'h4D, 8'h92, 8'h93, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE,
         8'hFF: begin r.kind = K_STD; r.param = 11'd2; end
         8'h27: begin r.kind = K_STD; r.param = 11'd34; end
         8'h2B: begin r.kind = K_STD; r.param = 11'd11; end
         8'h26: begin r.kind = K_STD; r.param = 11'd15; end
         8'hF5, 8'hF6, 8'hF8: begin r.kind = K_STD; r.param = 11'd4; end
         8'h29: begin r.kind = K_FIXED; r.param = 11'd28; end
         8'h2C, 8'h2F, 8'h30: begin r.kind = K_FIXED; r.param = 11'd17; end
         8'h2E: begin r.kind = K_FIXED; r.param = 11'd22; end
         8'h34, 8'h44, 8'h87, 8'h89: begin r.kind = K_FIXED; r.param = 11'd8; end
         8'h35, 8'h43, 8'h7E, 8'h7F: begin r.kind = K_FIXED; r.param = 11'd12; end
         8'h36: begin r.kind = K_FIXED; r.param = 11'd13; end
         8'h3C, 8'h3D, 8'h45: begin r.kind = K_FIXED; r.param = 11'd21; end
         8'h3E, 8'h46, 8'h47, 8'h48, 8'h5B, 8'h8E,
         8'h90: begin r.kind = K_FIXED; r.param = 11'd16; end
         8'h61: begin r.kind = K_FIXED; r.param = 11'd20; end
         8'h77: begin r.kind = K_FIXED; r.param = 11'd3; end
         8'h7A: begin r.kind = K_FIXED; r.param = 11'd29; end
         8'h8C: begin r.kind = K_FIXED; r.param = 11'd45; end
         8'h8D: begin r.kind = K_FIXED; r.param = 11'd1049; end
         8'h8F: begin r.kind = K_FIXED; r.param = 11'd40; end
         8'h91: begin r.kind = K_FIXED; r.param = 11'd10; end
         8'h28: r.kind = K_ARR28;
         8'h31: r.kind = K_ARR31;
         8'h2D: r.kind = K_B2D;
         8'h8B: r.kind = K_B8B;
         default: r.kind = K_NONE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/ccf_front.sv */
// ---------------------------------------------------------------------------
// Command chunk framer front end
// Accepts one chunk byte per cycle when the queue has room, tracks header
// and command boundaries and produces up to two result records per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ccf_front #(
   parameter int MAX_CHUNK_BYTES = 65536
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire [15:0]          csr_wr_data,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire [7:0]           data_byte,
   input  wire                 chunk_first,
   input  wire                 chunk_last,
   input  wire                 command_chunk,
   input  wire ccf_pkg::q_status_type q_status,
   output logic [1:0]          push_n,
   output ccf_pkg::result_type push0,
   output ccf_pkg::result_type push1
);

   localparam int POS_W = $clog2(MAX_CHUNK_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHUNK_BYTES);

   ccf_pkg::phase_type phase_ff, phase_in;
   ccf_pkg::kind_type  kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [POS_W-1:0]   mark_ff, mark_in;
   logic [7:0]         id_ff, id_in;
   logic [7:0]         player_ff, player_in;
   logic [23:0]        count_ff, count_in;
   logic [15:0]        max_count_ff;

   logic fire;
   assign req_tready = q_status.room;
   assign fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ccf_pkg::PH_IDLE;
         max_count_ff <= ccf_pkg::MAX_COUNT_RESET;
      end else begin
         if (fire) phase_ff <= phase_in;
         if (csr_wr_en) max_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff   <= kind_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         mark_ff   <= mark_in;
         id_ff     <= id_in;
         player_ff <= player_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      ccf_pkg::phase_type ph;
      ccf_pkg::rule_type  rule;
      ccf_pkg::result_type rec;
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] r;
      logic [POS_W:0]   hop;
      logic [1:0]       n;
      logic             active;

      rule = ccf_pkg::rom_rule(data_byte);
      rec  = '0;
      hop  = '0;
      n    = 2'd0;
      push0 = '0;
      push1 = '0;
      active = 1'b1;
      if (chunk_first) begin
         ph         = command_chunk ? ccf_pkg::PH_HEADER : ccf_pkg::PH_IGNORE;
         p          = '0;
         start_in   = '0;
         id_in      = '0;
         player_in  = '0;
         mark_in    = '0;
         count_in   = '0;
         kind_in    = ccf_pkg::K_NONE;
      end else begin
         ph         = phase_ff;
         p          = pos_ff;
         start_in   = start_ff;
         id_in      = id_ff;
         player_in  = player_ff;
         mark_in    = mark_ff;
         count_in   = count_ff;
         kind_in    = kind_ff;
         if (phase_ff == ccf_pkg::PH_IDLE) active = 1'b0;
      end
      r = p - start_in;

      if (active && p < POS_MAX) begin
         case (ph)
            ccf_pkg::PH_HEADER: begin
               if (p == '0) begin
                  count_in = '0;
                  if (data_byte != 8'd1) begin
                     rec = '0;
                     rec.status = ccf_pkg::ST_BAD_HEADER;
                     push0 = rec;
                     n = 2'd1;
                     ph = ccf_pkg::PH_IGNORE;
                  end
               end else if (p == POS_W'(1)) begin
                  count_in[7:0] = data_byte;
               end else if (p == POS_W'(2)) begin
                  count_in[15:8] = data_byte;
               end else if (p == POS_W'(3)) begin
                  count_in[23:16] = data_byte;
               end else if (p == POS_W'(4)) begin
                  if (data_byte != 8'd0 || count_ff[23:16] != 8'd0 ||
                      count_ff[15:0] > max_count_ff) begin
                     rec = '0;
                     rec.status = ccf_pkg::ST_OVER_LIMIT;
                     push0 = rec;
                     n = 2'd1;
                     ph = ccf_pkg::PH_IGNORE;
                  end else begin
                     ph = ccf_pkg::PH_AWAIT;
                  end
               end
            end
            ccf_pkg::PH_AWAIT: begin
               id_in     = data_byte;
               player_in = '0;
               start_in  = p;
               kind_in   = rule.kind;
               case (rule.kind)
                  ccf_pkg::K_NONE: begin
                     rec = '0;
                     rec.status = ccf_pkg::ST_UNKNOWN;
                     rec.command_id = data_byte;
                     rec.command_offset = 16'(p);
                     push0 = rec;
                     n = 2'd1;
                     ph = ccf_pkg::PH_DRAIN;
                  end
                  ccf_pkg::K_FIXED: begin
                     mark_in = POS_W'(rule.param - 11'd1);
                     ph = ccf_pkg::PH_FINISH;
                  end
                  ccf_pkg::K_STD: begin
                     mark_in = POS_W'(rule.param);
                     ph = ccf_pkg::PH_BODY;
                  end
                  ccf_pkg::K_ARR28: begin mark_in = POS_W'(17); ph = ccf_pkg::PH_BODY; end
                  ccf_pkg::K_ARR31: begin mark_in = POS_W'(12); ph = ccf_pkg::PH_BODY; end
                  ccf_pkg::K_B2D:   begin mark_in = POS_W'(7);  ph = ccf_pkg::PH_BODY; end
                  default:          begin mark_in = POS_W'(3);  ph = ccf_pkg::PH_BODY; end
               endcase
            end
            ccf_pkg::PH_BODY, ccf_pkg::PH_STRING, ccf_pkg::PH_FINISH: begin
               if (r == POS_W'(1)) player_in = data_byte;
               if (r == mark_ff) begin
                  rec = '0;
                  rec.status = ccf_pkg::ST_COMMAND;
                  rec.command_id = id_ff;
                  rec.player_index = player_in;
                  rec.command_offset = 16'(start_ff);
                  if (ph == ccf_pkg::PH_FINISH) begin
                     rec.command_length = 16'(r + POS_W'(1));
                     push0 = rec;
                     n = 2'd1;
                     ph = ccf_pkg::PH_AWAIT;
                  end else if (ph == ccf_pkg::PH_STRING) begin
                     // second string: two bytes per unit plus trailer
                     mark_in = POS_W'(mark_ff + POS_W'({data_byte, 1'b0}) + POS_W'(6));
                     ph = ccf_pkg::PH_FINISH;
                  end else begin
                     case (kind_ff)
                        ccf_pkg::K_STD: begin
                           if (data_byte == 8'hFF) begin
                              rec.command_length = 16'(r + POS_W'(1));
                              push0 = rec;
                              n = 2'd1;
                              ph = ccf_pkg::PH_AWAIT;
                           end else begin
                              hop = {1'b0, mark_ff} +
                                    (POS_W+1)'({data_byte[7:4], 2'b00}) +
                                    (POS_W+1)'(5);
                              if (hop > (POS_W+1)'(MAX_CHUNK_BYTES)) mark_in = POS_MAX;
                              else mark_in = hop[POS_W-1:0];
                           end
                        end
                        ccf_pkg::K_ARR28: begin
                           mark_in = POS_W'({data_byte, 2'b00}) + POS_W'(35);
                           ph = ccf_pkg::PH_FINISH;
                        end
                        ccf_pkg::K_ARR31: begin
                           mark_in = POS_W'({data_byte, 4'b0000}) +
                                     POS_W'({data_byte, 1'b0}) + POS_W'(16);
                           ph = ccf_pkg::PH_FINISH;
                        end
                        ccf_pkg::K_B2D: begin
                           if (data_byte == 8'hFF) begin
                              rec.command_length = 16'd8;
                              push0 = rec;
                              n = 2'd1;
                              ph = ccf_pkg::PH_AWAIT;
                           end else begin
                              mark_in = POS_W'(25);
                              ph = ccf_pkg::PH_FINISH;
                           end
                        end
                        default: begin
                           mark_in = POS_W'(data_byte) + POS_W'(5);
                           ph = ccf_pkg::PH_STRING;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      if (active && chunk_last) begin
         rec = '0;
         case (ph)
            ccf_pkg::PH_HEADER: begin
               rec.status = ccf_pkg::ST_BAD_HEADER;
               if (n == 2'd0) push0 = rec; else push1 = rec;
               n = n + 2'd1;
            end
            ccf_pkg::PH_BODY, ccf_pkg::PH_STRING, ccf_pkg::PH_FINISH: begin
               rec.status = (kind_in == ccf_pkg::K_FIXED) ? ccf_pkg::ST_INC_FIXED :
                            (kind_in == ccf_pkg::K_STD) ? ccf_pkg::ST_INC_STD :
                            ccf_pkg::ST_INC_BESPOKE;
               rec.command_id = id_in;
               rec.player_index = player_in;
               rec.command_offset = 16'(start_in);
               push0 = rec;
               rec = '0;
               rec.status = ccf_pkg::ST_DONE;
               push1 = rec;
               n = 2'd2;
            end
            ccf_pkg::PH_AWAIT, ccf_pkg::PH_DRAIN: begin
               rec.status = ccf_pkg::ST_DONE;
               if (n == 2'd0) push0 = rec; else push1 = rec;
               n = n + 2'd1;
            end
            default: ;
         endcase
         ph = ccf_pkg::PH_IDLE;
      end

      if (n == 2'd1) push0.last_of_run = 1'b1;
      if (n == 2'd2) push1.last_of_run = 1'b1;

      pos_in   = (active && p < POS_MAX) ? p + POS_W'(1) : p;
      phase_in = ph;
      push_n   = fire ? n : 2'd0;
   end

endmodule

`default_nettype wire

/* sv/ccf_queue.sv */
// ---------------------------------------------------------------------------
// Command chunk framer result queue
// Short result queue taking up to two records a cycle, with a registered
// output stage on the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module ccf_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [1:0]             push_n,
   input  wire ccf_pkg::result_type push0,
   input  wire ccf_pkg::result_type push1,
   output ccf_pkg::q_status_type q_status,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output ccf_pkg::result_type   rsp_data
);

   ccf_pkg::result_type            mem_ff [ccf_pkg::QUEUE_DEPTH];
   logic [ccf_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ccf_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ccf_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           valid_ff, valid_in;
   ccf_pkg::result_type            out_ff;
   logic                           pop;

   assign pop       = (count_ff != '0) && (!valid_ff || rsp_tready);
   assign wr_ptr_in = wr_ptr_ff + ccf_pkg::QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + ccf_pkg::QPTR_W'(pop);
   assign count_in  = count_ff + ccf_pkg::QCNT_W'(push_n) - ccf_pkg::QCNT_W'(pop);
   assign valid_in  = pop || (valid_ff && !rsp_tready);

   assign q_status.count = count_ff;
   assign q_status.room  = count_ff <= ccf_pkg::QCNT_W'(ccf_pkg::QUEUE_DEPTH - 2);
   assign rsp_tvalid     = valid_ff;
   assign rsp_data       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_n == 2'd2) mem_ff[wr_ptr_ff + ccf_pkg::QPTR_W'(1)] <= push1;
      if (pop) out_ff <= mem_ff[rd_ptr_ff];
   end

endmodule

`default_nettype wire

/* sv/command_chunk_framer_top.sv */
// ---------------------------------------------------------------------------
// Command chunk framer
// Splits command chunks into commands and reports framing errors.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one chunk byte per transfer. tdata = data_byte, tlast marks the
//            final byte of a chunk, tuser = {command_chunk, chunk_first}.
//   rsp_*  : one result per transfer (command, desync, header error or
//            chunk done). tlast is set on the last result caused by a byte.
//   csr_*  : write of max_command_count, taken on any cycle with wr_en high;
//            change it only while the block is idle.
//   Throughput: one byte per cycle while the queue has room; a byte giving
//   two results is absorbed by the four-entry result queue.
//   Path: a result is written into the queue when its byte is taken, then
//   leaves through the registered output stage.
//   Backpressure: while rsp_tready is low, results collect in the queue;
//   req_tready drops once fewer than two queue entries are free.
//   Reset: parser returns to idle, queue empties, rsp_tvalid goes low and
//   max_command_count returns to 10000. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "command_chunk_framer_top_defines.svh"

module command_chunk_framer_top #(
   parameter int MAX_CHUNK_BYTES = 65536
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data,  // max_command_count
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [7:0] data_byte
   input  wire         req_tlast,
   input  wire  [1:0]  req_tuser,    // [0] chunk_first, [1] command_chunk
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [2:0] status, [10:3] command_id, [18:11] player_index,
   // [34:19] command_length, [50:35] command_offset, [55:51] zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast
);

   ccf_pkg::q_status_type q_status;
   ccf_pkg::result_type   push0, push1, rsp_data;
   logic [1:0]            push_n;

   // Front end: parse bytes, classify commands
   ccf_front #(
      .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .data_byte     (req_tdata),
      .chunk_first   (req_tuser[0]),
      .chunk_last    (req_tlast),
      .command_chunk (req_tuser[1]),
      .q_status      (q_status),
      .push_n        (push_n),
      .push0         (push0),
      .push1         (push1)
   );

   // Back end: queue results and drive the result stream
   ccf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push0      (push0),
      .push1      (push1),
      .q_status   (q_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {5'd0, rsp_data.command_offset, rsp_data.command_length,
                       rsp_data.player_index, rsp_data.command_id, rsp_data.status};
   assign rsp_tlast = rsp_data.last_of_run;

   // Queue never holds more than its depth
   `CCF_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1,
      q_status.count <= ccf_pkg::QCNT_W'(ccf_pkg::QUEUE_DEPTH))
   // A byte is only taken with room for both of its possible results
   `CCF_ASSERT_IMPLIES(a_room_on_accept, clock, reset, req_tvalid && req_tready,
      q_status.count <= ccf_pkg::QCNT_W'(ccf_pkg::QUEUE_DEPTH - 2))
   // Reset leaves the queue empty and the result stream idle
   `CCF_ASSERT_NEXT(a_reset_empty, clock, reset,
      q_status.count == '0 && !rsp_tvalid)

endmodule

`default_nettype wire

/* dv/command_chunk_framer_top_tb.sv */
// ---------------------------------------------------------------------------
// Command chunk framer testbench
// Feeds command and non-command chunks byte by byte, keeps its own model of
// the framing rules, and compares every result transfer with that model.
// ---------------------------------------------------------------------------
`default_nettype none

module command_chunk_framer_top_tb;
   import ccf_pkg::*;

   localparam int CHUNK_CAP   = 65536;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_BYTES = 1400;

   typedef logic [7:0] byte_list_t[$];

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;
   logic [1:0]  req_tuser;    // [0] chunk_first, [1] command_chunk
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [2:0] status, [10:3] command_id, [18:11] player_index,
   // [34:19] command_length, [50:35] command_offset, [55:51] zero
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;

   command_chunk_framer_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Framing state mirrored from the block.
   phase_type   fr_phase;
   int          fr_pos;
   int          fr_start;
   logic [7:0]  fr_id;
   logic [7:0]  fr_player;
   int          fr_mark;
   logic [31:0] fr_count;
   logic [15:0] count_limit;

   result_type  pending_results[$];
   result_type  step_results[$];
   logic [7:0]  known_ids[$];

   bit idle_on;
   int bytes_sent;
   int results_seen;
   int fail_count;
   int idle_cycles;

   // Length rule per command id: kind plus length, first mark or zero.
   function automatic void id_rule(input logic [7:0] id, output kind_type k, output int prm);
      k = K_NONE;
      prm = 0;
      case (id)
         8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B,
         8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h17, 8'h72, 8'h73, 8'h4C,
         8'h4D, 8'h92, 8'h93, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE,
         8'hFF: begin k = K_STD; prm = 2; end
         8'h27: begin k = K_STD; prm = 34; end
         8'h2B: begin k = K_STD; prm = 11; end
         8'h26: begin k = K_STD; prm = 15; end
         8'hF5, 8'hF6, 8'hF8: begin k = K_STD; prm = 4; end
         8'h29: begin k = K_FIXED; prm = 28; end
         8'h2C, 8'h2F, 8'h30: begin k = K_FIXED; prm = 17; end
         8'h2E: begin k = K_FIXED; prm = 22; end
         8'h34, 8'h44, 8'h87, 8'h89: begin k = K_FIXED; prm = 8; end
         8'h35, 8'h43, 8'h7E, 8'h7F: begin k = K_FIXED; prm = 12; end
         8'h36: begin k = K_FIXED; prm = 13; end
         8'h3C, 8'h3D, 8'h45: begin k = K_FIXED; prm = 21; end
         8'h3E, 8'h46, 8'h47, 8'h48, 8'h5B, 8'h8E, 8'h90: begin k = K_FIXED; prm = 16; end
         8'h61: begin k = K_FIXED; prm = 20; end
         8'h77: begin k = K_FIXED; prm = 3; end
         8'h7A: begin k = K_FIXED; prm = 29; end
         8'h8C: begin k = K_FIXED; prm = 45; end
         8'h8D: begin k = K_FIXED; prm = 1049; end
         8'h8F: begin k = K_FIXED; prm = 40; end
         8'h91: begin k = K_FIXED; prm = 10; end
         8'h28: k = K_ARR28;
         8'h31: k = K_ARR31;
         8'h2D: k = K_B2D;
         8'h8B: k = K_B8B;
         default: k = K_NONE;
      endcase
   endfunction

   function automatic void add_result(input status_type st, input logic [7:0] id,
                                      input logic [7:0] pl, input int len, input int off);
      result_type r;
      if (step_results.size() >= 2) return;
      r.status = st;
      r.command_id = id;
      r.player_index = pl;
      r.command_length = len[15:0];
      r.command_offset = off[15:0];
      r.last_of_run = 1'b0;
      step_results.push_back(r);
   endfunction

   // Advance the mirrored framer by one accepted byte and queue its results.
   function automatic void frame_byte(input logic [7:0] b, input bit first,
                                      input bit last, input bit cmd);
      int p;
      int off;
      int prm;
      kind_type k;
      status_type st;
      step_results.delete();
      if (first) begin
         fr_phase = cmd ? PH_HEADER : PH_IGNORE;
         fr_pos = 0;
         fr_start = 0;
         fr_id = 0;
         fr_player = 0;
         fr_mark = 0;
         fr_count = 0;
      end else if (fr_phase == PH_IDLE) begin
         return;
      end
      p = fr_pos;
      if (p < CHUNK_CAP) begin
         if (fr_phase == PH_HEADER) begin
            if (p == 0) begin
               fr_count = 0;
               if (b != 8'd1) begin
                  add_result(ST_BAD_HEADER, 0, 0, 0, 0);
                  fr_phase = PH_IGNORE;
               end
            end else if (p <= 4) begin
               fr_count |= 32'(b) << (8 * (p - 1));
               if (p == 4) begin
                  if (fr_count > 32'(count_limit)) begin
                     add_result(ST_OVER_LIMIT, 0, 0, 0, 0);
                     fr_phase = PH_IGNORE;
                  end else begin
                     fr_phase = PH_AWAIT;
                  end
               end
            end
         end else if (fr_phase == PH_AWAIT) begin
            fr_id = b;
            fr_player = 0;
            fr_start = p;
            id_rule(b, k, prm);
            fr_phase = PH_BODY;
            case (k)
               K_NONE: begin
                  add_result(ST_UNKNOWN, b, 0, 0, p);
                  fr_phase = PH_DRAIN;
               end
               K_FIXED: begin fr_mark = prm - 1; fr_phase = PH_FINISH; end
               K_STD:   fr_mark = prm;
               K_ARR28: fr_mark = 17;
               K_ARR31: fr_mark = 12;
               K_B2D:   fr_mark = 7;
               default: fr_mark = 3;
            endcase
         end else if (fr_phase == PH_BODY || fr_phase == PH_STRING ||
                      fr_phase == PH_FINISH) begin
            off = p - fr_start;
            if (off == 1) fr_player = b;
            if (off == fr_mark) begin
               if (fr_phase == PH_FINISH) begin
                  add_result(ST_COMMAND, fr_id, fr_player, off + 1, fr_start);
                  fr_phase = PH_AWAIT;
               end else if (fr_phase == PH_STRING) begin
                  fr_mark = fr_mark + 2 * int'(b) + 6;
                  fr_phase = PH_FINISH;
               end else begin
                  id_rule(fr_id, k, prm);
                  case (k)
                     K_STD: begin
                        if (b == 8'hFF) begin
                           add_result(ST_COMMAND, fr_id, fr_player, off + 1, fr_start);
                           fr_phase = PH_AWAIT;
                        end else begin
                           fr_mark += 4 * (int'(b >> 4) + 1) + 1;
                           if (fr_mark > CHUNK_CAP) fr_mark = CHUNK_CAP;
                        end
                     end
                     K_ARR28: begin fr_mark = (int'(b) + 1) * 4 + 31; fr_phase = PH_FINISH; end
                     K_ARR31: begin fr_mark = int'(b) * 18 + 16; fr_phase = PH_FINISH; end
                     K_B2D: begin
                        if (b == 8'hFF) begin
                           add_result(ST_COMMAND, fr_id, fr_player, 8, fr_start);
                           fr_phase = PH_AWAIT;
                        end else begin
                           fr_mark = 25;
                           fr_phase = PH_FINISH;
                        end
                     end
                     default: begin fr_mark = int'(b) + 5; fr_phase = PH_STRING; end
                  endcase
               end
            end
         end
      end
      if (last) begin
         if (fr_phase == PH_HEADER) begin
            add_result(ST_BAD_HEADER, 0, 0, 0, 0);
         end else if (fr_phase == PH_BODY || fr_phase == PH_STRING ||
                      fr_phase == PH_FINISH) begin
            id_rule(fr_id, k, prm);
            st = (k == K_FIXED) ? ST_INC_FIXED : ((k == K_STD) ? ST_INC_STD : ST_INC_BESPOKE);
            add_result(st, fr_id, fr_player, 0, fr_start);
            add_result(ST_DONE, 0, 0, 0, 0);
         end else if (fr_phase == PH_AWAIT || fr_phase == PH_DRAIN) begin
            add_result(ST_DONE, 0, 0, 0, 0);
         end
         fr_phase = PH_IDLE;
      end
      if (p < CHUNK_CAP) fr_pos = p + 1;
      if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
   endfunction

   // Send one byte; enter and leave at a falling edge with tvalid still high.
   task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                            input bit cmd);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = last;
      req_tuser = {cmd, first};
      do @(posedge clock); while (!req_tready);
      frame_byte(b, first, last, cmd);
      if (fr_phase != PH_IGNORE || first) bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_chunk(input byte_list_t bytes, input bit cmd, input bit closed);
      foreach (bytes[i])
         send_byte(bytes[i], i == 0, closed && (i == bytes.size() - 1), cmd);
   endtask

   // Hold off until every expected result has arrived and the pipe is empty.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_count_limit(input logic [15:0] value);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      count_limit = value;
   endtask

   function automatic void push_random(ref byte_list_t q, input int upto);
      while (q.size() < upto) q.push_back(8'($urandom));
   endfunction

   // Append one well-formed command with id; hops and counts kept small.
   function automatic void build_command(ref byte_list_t q, input logic [7:0] id);
      int base;
      int prm;
      int mark;
      int hops;
      logic [7:0] v;
      kind_type k;
      base = q.size();
      id_rule(id, k, prm);
      q.push_back(id);
      q.push_back(8'($urandom));
      case (k)
         K_FIXED: push_random(q, base + prm);
         K_STD: begin
            mark = prm;
            hops = $urandom_range(0, 2);
            repeat (hops) begin
               push_random(q, base + mark);
               v = {3'b000, 1'($urandom), 4'($urandom)};
               q.push_back(v);
               mark += 4 * (int'(v >> 4) + 1) + 1;
            end
            push_random(q, base + mark);
            q.push_back(8'hFF);
         end
         K_ARR28: begin
            push_random(q, base + 17);
            v = 8'($urandom_range(0, 3));
            q.push_back(v);
            push_random(q, base + (int'(v) + 1) * 4 + 32);
         end
         K_ARR31: begin
            push_random(q, base + 12);
            v = 8'($urandom_range(0, 3));
            q.push_back(v);
            push_random(q, base + int'(v) * 18 + 17);
         end
         K_B2D: begin
            push_random(q, base + 7);
            if ($urandom_range(0, 1)) begin
               q.push_back(8'hFF);
            end else begin
               q.push_back(8'($urandom_range(0, 254)));
               push_random(q, base + 26);
            end
         end
         K_B8B: begin
            push_random(q, base + 3);
            v = 8'($urandom_range(0, 7));
            q.push_back(v);
            mark = int'(v) + 5;
            push_random(q, base + mark);
            v = 8'($urandom_range(0, 7));
            q.push_back(v);
            push_random(q, base + mark + 2 * int'(v) + 7);
         end
         default: ;
      endcase
   endfunction

   function automatic void build_header(ref byte_list_t q, input logic [31:0] count);
      q.push_back(8'd1);
      for (int i = 0; i < 4; i++) q.push_back(count[8*i +: 8]);
   endfunction

   task automatic test_directed();
      byte_list_t q;
      idle_on = 1'b0;
      // header only, count zero: straight to chunk done
      q = {}; build_header(q, 0); send_chunk(q, 1, 1);
      // bad tag on a one-byte chunk
      q = {8'hFF}; send_chunk(q, 1, 1);
      // header cut short
      q = {8'd1, 8'h05, 8'h00}; send_chunk(q, 1, 1);
      // count just over the reset limit
      q = {}; build_header(q, 32'd10001); send_chunk(q, 1, 1);
      // one command per length rule, then an unknown id
      q = {}; build_header(q, 32'd10000);
      build_command(q, 8'h77); build_command(q, 8'h02); build_command(q, 8'h28);
      build_command(q, 8'h31); build_command(q, 8'h2D); build_command(q, 8'h8B);
      q.push_back(8'h00); q.push_back(8'hAA);
      send_chunk(q, 1, 1);
      // fixed command cut by the chunk end
      q = {}; build_header(q, 1); q.push_back(8'h29); q.push_back(8'h3C);
      send_chunk(q, 1, 1);
      // ignored chunk and stray bytes outside any chunk
      q = {8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77}; send_chunk(q, 0, 1);
      send_byte(8'h55, 0, 1, 1);
      // restart on an open chunk drops it silently
      q = {}; build_header(q, 0); q.push_back(8'h8D); send_chunk(q, 1, 0);
      q = {}; build_header(q, 0); build_command(q, 8'h77); send_chunk(q, 1, 1);
   endtask

   task automatic random_chunks(input int budget);
      byte_list_t q;
      int stop_at;
      int sel;
      logic [31:0] cnt;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) idle_on = ~idle_on;
         q = {};
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
            send_chunk(q, 0, 1);
         end else if (sel == 1) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom), 0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end else if (sel == 2) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            send_chunk(q, 1, 1);
         end else if (sel == 3) begin
            cnt = $urandom;
            if (cnt <= 32'(count_limit)) cnt = 32'(count_limit) + 1;
            build_header(q, cnt);
            send_chunk(q, 1, 1);
         end else begin
            cnt = $urandom_range(0, int'(count_limit));
            build_header(q, cnt);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 15) == 0) begin
                  q.push_back(8'($urandom));
                  q.push_back(8'($urandom));
               end else begin
                  build_command(q, known_ids[$urandom_range(0, known_ids.size() - 1)]);
               end
            end
            sel = $urandom_range(0, 9);
            if (sel < 2 && q.size() > 1) begin
               repeat ($urandom_range(1, 6)) if (q.size() > 1) q.pop_back();
            end else if (sel == 2) begin
               q.push_back(8'h00);
               repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
            end
            send_chunk(q, 1, sel != 3);
         end
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
   endtask

   // Result side: random stall before each transfer while idle_on is set.
   initial begin : rsp_side
      int w;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         w = idle_on ? $urandom_range(0, 13) : 0;
         if (w > 0) begin
            rsp_tready = 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[2:0] !== e.status || rsp_tdata[10:3] !== e.command_id ||
                rsp_tdata[18:11] !== e.player_index || rsp_tdata[34:19] !== e.command_length ||
                rsp_tdata[50:35] !== e.command_offset || rsp_tlast !== e.last_of_run) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: exp st=%0d id=%h pl=%h len=%0d off=%0d last=%b",
                           e.status, e.command_id, e.player_index, e.command_length,
                           e.command_offset, e.last_of_run);
                  $display("          got st=%0d id=%h pl=%h len=%0d off=%0d last=%b",
                           rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[18:11],
                           rsp_tdata[34:19], rsp_tdata[50:35], rsp_tlast);
               end
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      kind_type k;
      int prm;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = '0;
      idle_on = 1'b0;
      bytes_sent = 0;
      count_limit = 16'd10000;
      fr_phase = PH_IDLE;
      fr_pos = 0;
      for (int i = 0; i < 256; i++) begin
         id_rule(8'(i), k, prm);
         if (k != K_NONE) known_ids.push_back(8'(i));
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_count_limit(16'd0);
      random_chunks(RANDOM_BYTES / 4);
      write_count_limit(16'hFFFF);
      random_chunks(RANDOM_BYTES / 4);
      write_count_limit(16'($urandom_range(1, 300)));
      random_chunks(RANDOM_BYTES / 4);
      write_count_limit(16'd10000);
      random_chunks(RANDOM_BYTES / 4);

      wait_drained();
      $display("run covered %0d chunk bytes and %0d results, with the count limit",
               bytes_sent, results_seen);
      $display("at zero, full range, a small value and its reset value");
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d failures, %0d results missing", fail_count, pending_results.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
